@@ rtl/aur_pkg.sv @@
// shared types and constants for the adaptive ultrasonic ranging block
`default_nettype none
package aur_pkg;

  localparam int NOW_W      = 32;
  localparam int HEAD_W     = 9;
  localparam int ECHO_W     = 15;
  localparam int DIST_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AVOID_THRESH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_PERIOD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MOVING_PERIOD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_LIMIT     = 3'd6;

  // register reset values
  localparam logic [8:0]  RST_MAX_DISTANCE  = 9'd400;
  localparam logic [8:0]  RST_AVOID_THRESH  = 9'd20;
  localparam logic [7:0]  RST_SPEED         = 8'd12;
  localparam logic [7:0]  RST_BUFFER        = 8'd8;
  localparam logic [15:0] RST_IDLE_PERIOD   = 16'd1000;
  localparam logic [15:0] RST_MOVING_PERIOD = 16'd300;
  localparam logic [7:0]  RST_TURN_LIMIT    = 8'd15;

  localparam logic [ECHO_W-1:0] ECHO_TIMEOUT_US = 15'd30000;
  localparam logic [HEAD_W-1:0] HEADING_WRAP    = 9'd360;
  localparam logic [HEAD_W-1:0] HEADING_HALF    = 9'd180;

  // q8 cm = floor(echo * 544 / 125); the divide by 125 is a reciprocal multiply
  localparam int            ECHO_SCALE_W = 25;
  localparam logic [9:0]    ECHO_SCALE   = 10'd544;
  localparam int            RECIP_SHIFT  = 31;
  localparam logic [24:0]   RECIP_MUL    = 25'(((64'd1 << RECIP_SHIFT) + 64'd124) / 64'd125);
  localparam int            RECIP_PROD_W = 50;

  // range test scaled by 1/256: echo * 17 > max_cm * 1000
  localparam int          RANGE_W       = 20;
  localparam logic [4:0]  RANGE_ECHO_MUL = 5'd17;
  localparam logic [9:0]  RANGE_CM_MUL   = 10'd1000;

  // travel test scaled by 1/8: elapsed*speed*32 + buffer*32000 > held*125
  localparam int           TRAVEL_W      = 46;
  localparam logic [14:0]  TRAVEL_BUF_MUL = 15'd32000;
  localparam logic [6:0]   TRAVEL_HELD_MUL = 7'd125;

  typedef struct packed {
    logic [NOW_W-1:0]  now_ms;
    logic              moving;
    logic [HEAD_W-1:0] heading;
    logic [DIST_W-1:0] conv_dist;
    logic              conv_ok;
  } aur_stage_t;

endpackage
`default_nettype wire

@@ rtl/aur_query_if.sv @@
// query channel: valid/ready handshake with the query fields
`default_nettype none
interface aur_query_if import aur_pkg::*;;
  logic              valid;
  logic              ready;
  logic [NOW_W-1:0]  now_ms;
  logic              moving;
  logic [HEAD_W-1:0] heading_deg;
  logic [ECHO_W-1:0] echo_us;

  modport source (output valid, output now_ms, output moving, output heading_deg,
                  output echo_us, input ready);
  modport sink (input valid, input now_ms, input moving, input heading_deg,
                input echo_us, output ready);
endinterface
`default_nettype wire

@@ rtl/aur_result_if.sv @@
// result channel: valid/ready handshake with the ranging result fields
`default_nettype none
interface aur_result_if import aur_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_q8;
  logic              distance_valid;
  logic              measured;
  logic              obstacle;
  logic              clear;

  modport source (output valid, output distance_q8, output distance_valid,
                  output measured, output obstacle, output clear, input ready);
  modport sink (input valid, input distance_q8, input distance_valid,
                input measured, input obstacle, input clear, output ready);
endinterface
`default_nettype wire

@@ rtl/adaptive_ultrasonic_ranging.sv @@
// adaptive ultrasonic ranging: read decision, echo conversion and held distance
// a query is registered in the stage register and then in the result register
// throughput: one query per cycle while results are taken; the echo conversion sits before the stage
// register and the read decision with the held-state update sits after it
// reset (synchronous, active high) clears the held distance, the last read
// time and heading, and loads the configuration registers with their defaults
`default_nettype none
module adaptive_ultrasonic_ranging import aur_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  aur_query_if.sink             query,
  aur_result_if.source          result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [8:0]  max_distance_cm;
  logic [8:0]  avoid_threshold_cm;
  logic [7:0]  speed_cm_per_s;
  logic [7:0]  buffer_cm;
  logic [15:0] idle_period_ms;
  logic [15:0] moving_period_ms;
  logic [7:0]  turn_limit_deg;

  // held state
  logic [DIST_W-1:0] held_distance;
  logic              held_valid;
  logic [NOW_W-1:0]  last_read_time;
  logic [HEAD_W-1:0] last_read_heading;

  // stage register
  logic       stage_valid;
  aur_stage_t stage;
  aur_stage_t stage_next;

  logic advance;
  logic in_fire;

  // input side conversion
  logic [ECHO_SCALE_W-1:0] echo_scaled;
  logic [RECIP_PROD_W-1:0] recip_prod;
  logic [RANGE_W-1:0]      range_echo;
  logic [RANGE_W-1:0]      range_limit;

  // decision
  logic [NOW_W-1:0]    elapsed;
  logic [DIST_W-1:0]   thr_q8;
  logic [39:0]         speed_prod;
  logic [TRAVEL_W-1:0] travel;
  logic [TRAVEL_W-1:0] held_scaled;
  logic [HEAD_W-1:0]   head_diff;
  logic [HEAD_W-1:0]   head_fold;
  logic                read;
  logic [DIST_W-1:0]   held_distance_next;
  logic                held_valid_next;

  assign advance     = !result.valid || result.ready;
  assign query.ready = !stage_valid || advance;
  assign in_fire     = query.valid && query.ready;

  always_comb begin
    echo_scaled = ECHO_SCALE_W'(query.echo_us) * ECHO_SCALE_W'(ECHO_SCALE);
    recip_prod  = RECIP_PROD_W'(echo_scaled) * RECIP_PROD_W'(RECIP_MUL);
    range_echo  = RANGE_W'(query.echo_us) * RANGE_W'(RANGE_ECHO_MUL);
    range_limit = RANGE_W'(max_distance_cm) * RANGE_W'(RANGE_CM_MUL);

    stage_next.now_ms    = query.now_ms;
    stage_next.moving    = query.moving;
    stage_next.heading   = (query.heading_deg >= HEADING_WRAP) ?
                           query.heading_deg - HEADING_WRAP : query.heading_deg;
    stage_next.conv_dist = recip_prod[RECIP_SHIFT +: DIST_W];
    stage_next.conv_ok   = (query.echo_us != '0) && (query.echo_us <= ECHO_TIMEOUT_US) &&
                           !(range_echo > range_limit);
  end

  always_comb begin
    elapsed     = stage.now_ms - last_read_time;
    thr_q8      = {avoid_threshold_cm, 8'd0};
    speed_prod  = 40'(elapsed) * 40'(speed_cm_per_s);
    travel      = {1'b0, speed_prod, 5'd0} +
                  TRAVEL_W'(buffer_cm) * TRAVEL_W'(TRAVEL_BUF_MUL);
    held_scaled = TRAVEL_W'(held_distance) * TRAVEL_W'(TRAVEL_HELD_MUL);

    head_diff = (stage.heading >= last_read_heading) ? stage.heading - last_read_heading :
                                                       last_read_heading - stage.heading;
    // shortest way around the circle
    head_fold = (head_diff > HEADING_HALF) ? HEADING_WRAP - head_diff : head_diff;

    if (stage.moving) begin
      read = !held_valid || (travel > held_scaled) ||
             (elapsed > NOW_W'(moving_period_ms)) ||
             (head_fold > HEAD_W'(turn_limit_deg));
    end else begin
      read = (elapsed > NOW_W'(idle_period_ms)) || !held_valid ||
             (held_distance < thr_q8);
    end

    held_distance_next = held_distance;
    held_valid_next    = held_valid;
    if (read) begin
      held_distance_next = stage.conv_ok ? stage.conv_dist : '0;
      held_valid_next    = stage.conv_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance_cm    <= RST_MAX_DISTANCE;
      avoid_threshold_cm <= RST_AVOID_THRESH;
      speed_cm_per_s     <= RST_SPEED;
      buffer_cm          <= RST_BUFFER;
      idle_period_ms     <= RST_IDLE_PERIOD;
      moving_period_ms   <= RST_MOVING_PERIOD;
      turn_limit_deg     <= RST_TURN_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_DISTANCE:  max_distance_cm    <= cfg_data[8:0];
        REG_AVOID_THRESH:  avoid_threshold_cm <= cfg_data[8:0];
        REG_SPEED:         speed_cm_per_s     <= cfg_data[7:0];
        REG_BUFFER:        buffer_cm          <= cfg_data[7:0];
        REG_IDLE_PERIOD:   idle_period_ms     <= cfg_data;
        REG_MOVING_PERIOD: moving_period_ms   <= cfg_data;
        REG_TURN_LIMIT:    turn_limit_deg     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (query.ready) begin
      stage_valid <= query.valid;
    end
    if (in_fire) begin
      stage <= stage_next;
    end
  end

  // held state moves together with the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_distance     <= '0;
      held_valid        <= 1'b0;
      last_read_time    <= '0;
      last_read_heading <= '0;
    end else if (advance && stage_valid) begin
      held_distance <= held_distance_next;
      held_valid    <= held_valid_next;
      if (read) begin
        last_read_time    <= stage.now_ms;
        last_read_heading <= stage.heading;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= stage_valid;
    end
    if (advance && stage_valid) begin
      result.distance_q8    <= held_distance_next;
      result.distance_valid <= held_valid_next;
      result.measured       <= read;
      result.obstacle       <= !held_valid_next || (held_distance_next < thr_q8);
      result.clear          <= !held_valid_next || (held_distance_next > thr_q8);
    end
  end

endmodule
`default_nettype wire

@@ rtl/aur_checker.sv @@
// port-level checks for the adaptive ultrasonic ranging block
`default_nettype none
module aur_checker import aur_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic [DIST_W-1:0] res_distance_q8,
  input logic              res_distance_valid,
  input logic              res_measured,
  input logic              res_obstacle,
  input logic              res_clear
);

  // a stalled result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result transaction dropped while stalled");

  // an invalid reading reports zero distance and both flags
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_distance_valid |-> res_distance_q8 == '0 && res_obstacle && res_clear)
    else $error("invalid distance with nonzero value or missing flags");

  // a valid distance cannot be both below and above the threshold
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_distance_valid |-> !(res_obstacle && res_clear))
    else $error("obstacle and clear both set on a valid distance");

  // an invalid held distance always forces a reading
  a_skip_needs_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_measured |-> res_distance_valid)
    else $error("reading skipped with invalid held distance");

endmodule

bind adaptive_ultrasonic_ranging aur_checker u_aur_checker (
  .clk                (clk),
  .rst                (rst),
  .res_valid          (result.valid),
  .res_ready          (result.ready),
  .res_distance_q8    (result.distance_q8),
  .res_distance_valid (result.distance_valid),
  .res_measured       (result.measured),
  .res_obstacle       (result.obstacle),
  .res_clear          (result.clear)
);
`default_nettype wire

@@ tb/sv/tb.sv @@
// testbench for adaptive_ultrasonic_ranging: directed and random queries checked against a local predictor
`timescale 1ns / 1ps
module tb;
  import aur_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [63:0] ECHO_Q8_NUM    = 64'd4352;
  localparam logic [63:0] ECHO_Q8_DEN    = 64'd1000;
  localparam logic [63:0] CM_TO_Q8_MILLI = 64'd256000;

  typedef struct packed {
    logic [NOW_W-1:0]  now_ms;
    logic              moving;
    logic [HEAD_W-1:0] heading_deg;
    logic [ECHO_W-1:0] echo_us;
  } query_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_q8;
    logic              distance_valid;
    logic              measured;
    logic              obstacle;
    logic              clear;
  } range_result_t;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  aur_query_if  qif ();
  aur_result_if rif ();

  adaptive_ultrasonic_ranging uut (
    .clk       (clk),
    .rst       (rst),
    .query     (qif),
    .result    (rif),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // configuration as the block should hold it
  logic [8:0]  cfg_max_cm;
  logic [8:0]  cfg_thresh_cm;
  logic [7:0]  cfg_speed;
  logic [7:0]  cfg_buffer;
  logic [15:0] cfg_idle;
  logic [15:0] cfg_move_period;
  logic [7:0]  cfg_turn;

  // ranging state mirror
  logic [DIST_W-1:0] held_q8;
  logic              held_ok;
  logic [NOW_W-1:0]  last_read_ms;
  logic [HEAD_W-1:0] last_head;

  query_t        query_pending[$];
  range_result_t expected_ranges[$];

  int errors;
  int cycles;
  int queries_sent;
  int readings;
  int bad_readings;
  int obstacle_hits;
  int settings_used;
  int send_gap;
  int take_stall;
  bit send_burst;
  bit take_burst;

  logic [NOW_W-1:0]  gen_now;
  logic [HEAD_W-1:0] gen_head;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic range_result_t range_step(query_t qi);
    logic [HEAD_W-1:0] head;
    logic [HEAD_W-1:0] turn_delta;
    logic [31:0] elapsed;
    logic [31:0] thr_q8;
    logic [63:0] travel;
    logic [63:0] held_scaled;
    logic [63:0] scaled;
    bit take;
    range_result_t r;
    head = (qi.heading_deg >= HEADING_WRAP) ? qi.heading_deg - HEADING_WRAP
                                            : qi.heading_deg;
    turn_delta = (head >= last_head) ? head - last_head : last_head - head;
    if (turn_delta > HEADING_HALF) turn_delta = HEADING_WRAP - turn_delta;
    elapsed = qi.now_ms - last_read_ms;
    thr_q8 = 32'(cfg_thresh_cm) << 8;
    if (!qi.moving) begin
      take = (elapsed > cfg_idle) || !held_ok || (held_q8 < thr_q8);
    end else begin
      travel = 64'(elapsed) * cfg_speed * 256 + 64'(cfg_buffer) * CM_TO_Q8_MILLI;
      held_scaled = 64'(held_q8) * ECHO_Q8_DEN;
      take = !held_ok || (travel > held_scaled) || (elapsed > cfg_move_period) ||
             (turn_delta > cfg_turn);
    end
    if (take) begin
      scaled = 64'(qi.echo_us) * ECHO_Q8_NUM;
      if (qi.echo_us == '0 || qi.echo_us > ECHO_TIMEOUT_US ||
          scaled > 64'(cfg_max_cm) * CM_TO_Q8_MILLI) begin
        held_q8 = '0;
        held_ok = 1'b0;
      end else begin
        held_q8 = DIST_W'(scaled / ECHO_Q8_DEN);
        held_ok = 1'b1;
      end
      last_read_ms = qi.now_ms;
      last_head = head;
    end
    r.distance_q8    = held_q8;
    r.distance_valid = held_ok;
    r.measured       = take;
    r.obstacle       = !held_ok || (held_q8 < thr_q8);
    r.clear          = !held_ok || (held_q8 > thr_q8);
    return r;
  endfunction

  // gap before the next transaction on one side, with runs of back-to-back traffic
  function automatic int draw_wait(inout bit no_gaps);
    if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
    return no_gaps ? 0 : int'($urandom_range(0, 6));
  endfunction

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      errors++;
    end
  endtask

  // query driver
  always @(posedge clk) begin
    query_t next_query;
    bit next_valid;
    if (rst) begin
      qif.valid <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = qif.valid;
      if (qif.valid && qif.ready) begin
        expected_ranges.push_back(range_step(query_pending.pop_front()));
        queries_sent++;
        send_gap = draw_wait(send_burst);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (query_pending.size() > 0) begin
          next_query = query_pending[0];
          qif.now_ms      <= next_query.now_ms;
          qif.moving      <= next_query.moving;
          qif.heading_deg <= next_query.heading_deg;
          qif.echo_us     <= next_query.echo_us;
          next_valid = 1'b1;
        end
      end
      qif.valid <= next_valid;
    end
  end

  // result monitor
  always @(posedge clk) begin
    range_result_t want;
    bit next_ready;
    if (rst) begin
      rif.ready <= 1'b0;
      take_stall = 0;
    end else begin
      if (rif.valid && rif.ready) begin
        if (expected_ranges.size() == 0) begin
          $display("%0t: result with nothing expected, distance %0d valid %0b", $time,
                   rif.distance_q8, rif.distance_valid);
          errors++;
        end else begin
          want = expected_ranges.pop_front();
          check_field("distance_q8", 32'(want.distance_q8), 32'(rif.distance_q8));
          check_field("distance_valid", 32'(want.distance_valid), 32'(rif.distance_valid));
          check_field("measured", 32'(want.measured), 32'(rif.measured));
          check_field("obstacle", 32'(want.obstacle), 32'(rif.obstacle));
          check_field("clear", 32'(want.clear), 32'(rif.clear));
          if (want.measured) readings++;
          if (want.measured && !want.distance_valid) bad_readings++;
          if (want.obstacle) obstacle_hits++;
        end
        take_stall = draw_wait(take_burst);
      end
      if (take_stall > 0) begin
        take_stall--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      rif.ready <= next_ready;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d queries still pending", cycles,
               query_pending.size() + expected_ranges.size());
      $display("tb failed");
      $finish;
    end
  end

  task automatic queue_query(input logic [NOW_W-1:0] now, input logic moving,
                             input logic [HEAD_W-1:0] heading, input logic [ECHO_W-1:0] echo);
    query_t qi;
    qi.now_ms      = now;
    qi.moving      = moving;
    qi.heading_deg = heading;
    qi.echo_us     = echo;
    query_pending.push_back(qi);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_MAX_DISTANCE:  cfg_max_cm      = value[8:0];
      REG_AVOID_THRESH:  cfg_thresh_cm   = value[8:0];
      REG_SPEED:         cfg_speed       = value[7:0];
      REG_BUFFER:        cfg_buffer      = value[7:0];
      REG_IDLE_PERIOD:   cfg_idle        = value;
      REG_MOVING_PERIOD: cfg_move_period = value;
      REG_TURN_LIMIT:    cfg_turn        = value[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int max_cm, input int thresh_cm, input int speed,
                                input int buffer, input int idle, input int move_period,
                                input int turn);
    write_reg(REG_MAX_DISTANCE, CFG_DATA_W'(max_cm));
    write_reg(REG_AVOID_THRESH, CFG_DATA_W'(thresh_cm));
    write_reg(REG_SPEED, CFG_DATA_W'(speed));
    write_reg(REG_BUFFER, CFG_DATA_W'(buffer));
    write_reg(REG_IDLE_PERIOD, CFG_DATA_W'(idle));
    write_reg(REG_MOVING_PERIOD, CFG_DATA_W'(move_period));
    write_reg(REG_TURN_LIMIT, CFG_DATA_W'(turn));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_drained();
    while (query_pending.size() != 0 || expected_ranges.size() != 0) @(posedge clk);
  endtask

  // random queries shaped around the current settings: period edges, turn-limit
  // edges, threshold and range-limit echoes, timeouts and wrap-around jumps
  task automatic add_random(input int count);
    int sel;
    int step;
    int echo;
    logic [HEAD_W-1:0] raw_head;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) step = 0;
      else if (sel < 40) step = $urandom_range(1, 40);
      else if (sel < 60) step = int'(cfg_idle) + int'($urandom_range(0, 4)) - 2;
      else if (sel < 80) step = int'(cfg_move_period) + int'($urandom_range(0, 4)) - 2;
      else step = $urandom_range(0, 3000);
      if (step < 0) step = 0;
      if (sel >= 96) gen_now = $urandom();
      else gen_now = gen_now + NOW_W'(step);

      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        step = int'($urandom_range(0, 2 * cfg_turn + 4)) - (int'(cfg_turn) + 2);
        gen_head = HEAD_W'((int'(gen_head) + step + 360) % 360);
        raw_head = gen_head;
      end else if (sel < 85) begin
        gen_head = HEAD_W'($urandom_range(0, 359));
        raw_head = gen_head;
      end else begin
        raw_head = HEAD_W'($urandom_range(360, 511));
        gen_head = raw_head - HEADING_WRAP;
      end

      sel = $urandom_range(0, 99);
      if (sel < 5) echo = 0;
      else if (sel < 10) echo = $urandom_range(30001, 32767);
      else if (sel < 30) echo = int'(cfg_thresh_cm) * 1000 / 17 + int'($urandom_range(0, 6)) - 3;
      else if (sel < 45) echo = int'(cfg_max_cm) * 1000 / 17 + int'($urandom_range(0, 4)) - 2;
      else if (sel < 55) echo = $urandom_range(1, 600);
      else echo = $urandom_range(1, 30000);
      if (echo < 0) echo = 0;
      if (echo > 32767) echo = 32767;

      queue_query(gen_now, 1'($urandom_range(0, 1)), raw_head, ECHO_W'(echo));
    end
  endtask

  initial begin
    logic [NOW_W-1:0] t;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    qif.valid = 1'b0;
    qif.now_ms = '0;
    qif.moving = 1'b0;
    qif.heading_deg = '0;
    qif.echo_us = '0;
    rif.ready = 1'b0;
    cfg_max_cm = RST_MAX_DISTANCE;
    cfg_thresh_cm = RST_AVOID_THRESH;
    cfg_speed = RST_SPEED;
    cfg_buffer = RST_BUFFER;
    cfg_idle = RST_IDLE_PERIOD;
    cfg_move_period = RST_MOVING_PERIOD;
    cfg_turn = RST_TURN_LIMIT;
    held_q8 = '0;
    held_ok = 1'b0;
    last_read_ms = '0;
    last_head = '0;
    settings_used = 1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // default settings: invalid echoes, range edge, period and turn edges,
    // heading fold, threshold crossing, travel estimate and time wrap
    queue_query(32'd5, 1'b0, 9'd0, 15'd0);
    queue_query(32'd6, 1'b0, 9'd0, 15'd30001);
    queue_query(32'd7, 1'b0, 9'd0, 15'd32767);
    queue_query(32'd8, 1'b0, 9'd0, 15'd30000);
    queue_query(32'd9, 1'b0, 9'd0, 15'd23530);
    queue_query(32'd10, 1'b0, 9'd0, 15'd23529);
    queue_query(32'd1010, 1'b0, 9'd0, 15'd100);
    queue_query(32'd1011, 1'b0, 9'd0, 15'd10000);
    queue_query(32'd1311, 1'b1, 9'd0, 15'd4000);
    queue_query(32'd1312, 1'b1, 9'd0, 15'd4000);
    queue_query(32'd1312, 1'b1, 9'd15, 15'd4000);
    queue_query(32'd1312, 1'b1, 9'd16, 15'd5000);
    queue_query(32'd1312, 1'b1, 9'd376, 15'd5000);
    queue_query(32'd1312, 1'b1, 9'd511, 15'd5000);
    queue_query(32'd1312, 1'b1, 9'd331, 15'd5000);
    queue_query(32'd1312, 1'b1, 9'd150, 15'd5000);
    queue_query(32'd1312, 1'b1, 9'd359, 15'd1000);
    queue_query(32'd1312, 1'b0, 9'd359, 15'd1176);
    queue_query(32'd1312, 1'b0, 9'd359, 15'd1177);
    queue_query(32'd1312, 1'b0, 9'd359, 15'd1000);
    queue_query(32'd1313, 1'b1, 9'd100, 15'd400);
    queue_query(32'd1313, 1'b1, 9'd100, 15'd3000);
    queue_query(32'hFFFF_FFF0, 1'b0, 9'd100, 15'd2000);
    queue_query(32'h0000_0005, 1'b0, 9'd100, 15'd3000);
    queue_query(32'h0000_03FE, 1'b0, 9'd100, 15'd3000);
    gen_now = 32'h0000_03FE;
    gen_head = 9'd100;
    wait_drained();

    // lowest limits: distance equal to threshold, travel equal to held distance
    apply_settings(17, 17, 0, 17, 0, 0, 0);
    t = gen_now + 32'd10;
    queue_query(t, 1'b0, gen_head, 15'd1000);
    queue_query(t, 1'b0, gen_head, 15'd1001);
    queue_query(t, 1'b1, gen_head, 15'd1001);
    queue_query(t, 1'b1, gen_head + 9'd1, 15'd1001);
    queue_query(t + 32'd1, 1'b0, gen_head + 9'd1, 15'd1000);
    gen_now = t + 32'd1;
    gen_head = gen_head + 9'd1;
    add_random(80);
    wait_drained();

    apply_settings(511, 511, 255, 255, 65535, 65535, 180);
    add_random(80);
    wait_drained();

    apply_settings(1, 1, 255, 0, 1, 1, 1);
    add_random(80);
    wait_drained();

    repeat (5) begin
      apply_settings($urandom_range(1, 511), $urandom_range(1, 511), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 2000),
                     $urandom_range(0, 1000), $urandom_range(0, 180));
      add_random(100);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("%0d queries under %0d register settings, %0d new readings", queries_sent,
             settings_used, readings);
    $display("%0d readings came back invalid, %0d results flagged an obstacle",
             bad_readings, obstacle_hits);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ adaptive_ultrasonic_ranging.f @@
rtl/aur_pkg.sv
rtl/aur_query_if.sv
rtl/aur_result_if.sv
rtl/adaptive_ultrasonic_ranging.sv
rtl/aur_checker.sv
tb/sv/tb.sv
